/* src/assert_macros.svh */
// assertion macros used by the idle timeout timing wheel control rtl
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: lbl");

`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: lbl");

`else

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)

`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* src/ittw_pkg.sv */
// shared constants, types and state codes for the idle timeout timing wheel
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ittw_pkg;

   localparam int MAX_CONNS = 64;
   localparam int MAX_SLOTS = 64;
   localparam int CONN_W    = 6;
   localparam int SLOT_W    = $clog2(MAX_SLOTS);
   localparam int CSR_W     = 7;
   localparam int CNT_W     = $clog2(MAX_CONNS + 1);

   localparam logic [CSR_W-1:0] WHEEL_SIZE_RESET = CSR_W'(60);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_FLUSH = 3'b100
   } state_type;

   typedef struct packed {
      logic              vld;
      logic              expired_valid;
      logic [CONN_W-1:0] id;
      logic              last;
   } push_type;

endpackage

`default_nettype wire

/* src/ittw_slot_ram.sv */
// generic single write port, single registered read port ram
// holds the wheel slot of each connection; no dependencies
`timescale 1ns / 1ps
`default_nettype none

module ittw_slot_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 6
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* src/ittw_ctrl.sv */
// wheel control: position, armed bits, refresh writes and tick scan
// uses ittw_pkg, ittw_slot_ram and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ittw_ctrl (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_wr_en,
   input  wire logic [ittw_pkg::CSR_W-1:0]   csr_wr_data,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic                         req_action,
   input  wire logic [ittw_pkg::CONN_W-1:0]  req_conn_id,
   input  wire logic                         out_free,
   output ittw_pkg::push_type                push
);

   import ittw_pkg::*;

   state_type             state_ff, state_in;
   logic [CSR_W-1:0]      size_ff;
   logic [SLOT_W-1:0]     pos_ff, pos_in;
   logic [MAX_CONNS-1:0]  armed_ff, armed_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  s1_vld_ff, s1_vld_in;
   logic [CONN_W-1:0]     s1_id_ff, s1_id_in;
   logic                  pend_vld_ff, pend_vld_in;
   logic [CONN_W-1:0]     pend_id_ff, pend_id_in;

   logic [CSR_W-1:0]      size_eff;
   logic [CSR_W-1:0]      size_m1;
   logic [CSR_W-1:0]      pos_inc;
   logic [SLOT_W-1:0]     place;
   logic                  accept;
   logic                  match;
   logic                  advance;
   logic                  ram_wr_en;
   logic                  ram_rd_en;
   logic [SLOT_W-1:0]     ram_rd_data;

   // effective wheel size, clamped to 1..MAX_SLOTS
   always_comb begin
      if (size_ff == '0) begin
         size_eff = CSR_W'(1);
      end else if (size_ff > CSR_W'(MAX_SLOTS)) begin
         size_eff = CSR_W'(MAX_SLOTS);
      end else begin
         size_eff = size_ff;
      end
   end

   assign size_m1 = size_eff - CSR_W'(1);
   assign pos_inc = CSR_W'(pos_ff) + CSR_W'(1);

   // slot just behind the current position
   always_comb begin
      if (pos_ff == '0 || CSR_W'(pos_ff) > size_eff) begin
         place = size_m1[SLOT_W-1:0];
      end else begin
         place = pos_ff - SLOT_W'(1);
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   assign match   = s1_vld_ff && armed_ff[s1_id_ff] && (ram_rd_data == pos_ff);
   assign advance = !(match && pend_vld_ff && !out_free);

   always_comb begin
      state_in    = state_ff;
      pos_in      = pos_ff;
      armed_in    = armed_ff;
      cnt_in      = cnt_ff;
      s1_vld_in   = s1_vld_ff;
      s1_id_in    = s1_id_ff;
      pend_vld_in = pend_vld_ff;
      pend_id_in  = pend_id_ff;
      ram_wr_en   = 1'b0;
      ram_rd_en   = 1'b0;
      push        = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!req_action) begin
                  armed_in[req_conn_id] = 1'b1;
                  ram_wr_en             = 1'b1;
               end else begin
                  if (pos_inc >= size_eff) begin
                     pos_in = '0;
                  end else begin
                     pos_in = pos_inc[SLOT_W-1:0];
                  end
                  cnt_in      = '0;
                  s1_vld_in   = 1'b0;
                  pend_vld_in = 1'b0;
                  state_in    = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (advance) begin
               if (match) begin
                  armed_in[s1_id_ff] = 1'b0;
                  pend_vld_in        = 1'b1;
                  pend_id_in         = s1_id_ff;
                  if (pend_vld_ff) begin
                     push.vld           = 1'b1;
                     push.expired_valid = 1'b1;
                     push.id            = pend_id_ff;
                     push.last          = 1'b0;
                  end
               end
               if (cnt_ff < CNT_W'(MAX_CONNS)) begin
                  ram_rd_en = 1'b1;
                  s1_vld_in = 1'b1;
                  s1_id_in  = cnt_ff[CONN_W-1:0];
                  cnt_in    = cnt_ff + CNT_W'(1);
               end else begin
                  s1_vld_in = 1'b0;
                  if (!s1_vld_ff) begin
                     state_in = ST_FLUSH;
                  end
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               push.vld           = 1'b1;
               push.expired_valid = pend_vld_ff;
               push.id            = pend_vld_ff ? pend_id_ff : '0;
               push.last          = 1'b1;
               pend_vld_in        = 1'b0;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         size_ff     <= WHEEL_SIZE_RESET;
         pos_ff      <= '0;
         armed_ff    <= '0;
         cnt_ff      <= '0;
         s1_vld_ff   <= 1'b0;
         pend_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pos_ff      <= pos_in;
         armed_ff    <= armed_in;
         cnt_ff      <= cnt_in;
         s1_vld_ff   <= s1_vld_in;
         pend_vld_ff <= pend_vld_in;
         if (csr_wr_en) begin
            size_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_id_ff   <= s1_id_in;
      pend_id_ff <= pend_id_in;
   end

   ittw_slot_ram #(
      .DEPTH (MAX_CONNS),
      .WIDTH (SLOT_W)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (req_conn_id),
      .wr_data (place),
      .rd_en   (ram_rd_en),
      .rd_addr (cnt_ff[CONN_W-1:0]),
      .rd_data (ram_rd_data)
   );

   `ASSERT_IMPLY(a_push_has_room, clock, reset, push.vld, out_free)
   `ASSERT_NEXT(a_pos_held_in_scan, clock, reset, state_ff != ST_IDLE, $stable(pos_ff))
   `ASSERT_IMPLY(a_pend_only_busy, clock, reset, pend_vld_ff, state_ff != ST_IDLE)
   `ASSERT_IMPLY(a_cnt_bounded, clock, reset, 1'b1, cnt_ff <= CNT_W'(MAX_CONNS))
   `ASSERT_IMPLY(a_no_write_in_scan, clock, reset, ram_wr_en, state_ff == ST_IDLE)

endmodule

`default_nettype wire

/* src/idle_timeout_timing_wheel_top.sv */
// top level of the idle timeout timing wheel: control plus result register
// uses ittw_pkg and ittw_ctrl
//
// channel  dir  handshake              payload
// req      in   req_valid/req_stall    req_action, req_conn_id
// rsp      out  rsp_valid/rsp_stall    rsp_expired_valid, rsp_expired_id, rsp_last
// csr      in   csr_wr_en              csr_wr_data (wheel size)
//
// a refresh is accepted while idle; a tick reads the slot ram once per connection,
// over all 64 connections
// req_stall stays high during a tick scan; a stalled rsp pauses the scan
// synchronous active high reset clears position, armed bits and wheel size to 60
`timescale 1ns / 1ps
`default_nettype none

module idle_timeout_timing_wheel_top (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_wr_en,
   input  wire logic [ittw_pkg::CSR_W-1:0]   csr_wr_data,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic                         req_action,
   input  wire logic [ittw_pkg::CONN_W-1:0]  req_conn_id,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic                              rsp_expired_valid,
   output logic [ittw_pkg::CONN_W-1:0]       rsp_expired_id,
   output logic                              rsp_last
);

   import ittw_pkg::*;

   push_type          push;
   logic              out_free;
   logic              rsp_valid_ff;
   logic              rsp_ev_ff;
   logic [CONN_W-1:0] rsp_id_ff;
   logic              rsp_last_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   ittw_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_action  (req_action),
      .req_conn_id (req_conn_id),
      .out_free    (out_free),
      .push        (push)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push.vld) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push.vld) begin
         rsp_ev_ff   <= push.expired_valid;
         rsp_id_ff   <= push.id;
         rsp_last_ff <= push.last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_expired_valid = rsp_ev_ff;
   assign rsp_expired_id    = rsp_id_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

`default_nettype wire

/* bench/tb.sv */
// self-checking bench for idle_timeout_timing_wheel_top: directed and random refresh/tick traffic
// keeps its own copy of the wheel state to predict the expired ids of each tick
// depends on ittw_pkg and the idle timeout timing wheel rtl
`timescale 1ns / 1ps

module tb;
   import ittw_pkg::*;

   localparam logic ACT_REFRESH = 1'b0;
   localparam logic ACT_TICK    = 1'b1;
   localparam int   SETTLE_CYCLES = 80;

   typedef struct packed {
      logic              expired_valid;
      logic [CONN_W-1:0] id;
      logic              last;
   } expiry_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_wr_en = 1'b0;
   logic [CSR_W-1:0]  csr_wr_data = '0;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_action = ACT_REFRESH;
   logic [CONN_W-1:0] req_conn_id = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_expired_valid;
   logic [CONN_W-1:0] rsp_expired_id;
   logic              rsp_last;

   // wheel state as the block should hold it
   logic [CSR_W-1:0]  wheel_cfg = WHEEL_SIZE_RESET;
   logic [CONN_W-1:0] wheel_pos = '0;
   logic              conn_armed [MAX_CONNS];
   logic [CONN_W-1:0] conn_slot [MAX_CONNS];
   expiry_type        due_expiries [$];

   int  errors = 0;
   int  stall_left = 0;
   bit  calm = 1'b0;

   idle_timeout_timing_wheel_top uut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_conn_id       (req_conn_id),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_expired_valid (rsp_expired_valid),
      .rsp_expired_id    (rsp_expired_id),
      .rsp_last          (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic int wheel_slots();
      if (wheel_cfg == 0)
         return 1;
      if (int'(wheel_cfg) > MAX_SLOTS)
         return MAX_SLOTS;
      return int'(wheel_cfg);
   endfunction

   function automatic void predict_expiries(logic action, logic [CONN_W-1:0] id);
      int size;
      int hits;
      expiry_type e;
      size = wheel_slots();
      if (action == ACT_REFRESH) begin
         conn_armed[id] = 1'b1;
         if (wheel_pos == 0 || int'(wheel_pos) > size)
            conn_slot[id] = CONN_W'(size - 1);
         else
            conn_slot[id] = wheel_pos - 1'b1;
         return;
      end
      if (int'(wheel_pos) + 1 >= size)
         wheel_pos = '0;
      else
         wheel_pos = wheel_pos + 1'b1;
      hits = 0;
      for (int c = 0; c < MAX_CONNS; c++) begin
         if (conn_armed[c] && conn_slot[c] == wheel_pos) begin
            conn_armed[c] = 1'b0;
            e.expired_valid = 1'b1;
            e.id = CONN_W'(c);
            e.last = 1'b0;
            due_expiries.insert(due_expiries.size(), e);
            hits++;
         end
      end
      if (hits == 0) begin
         e.expired_valid = 1'b0;
         e.id = '0;
         e.last = 1'b1;
         due_expiries.insert(due_expiries.size(), e);
      end else begin
         due_expiries[due_expiries.size() - 1].last = 1'b1;
      end
   endfunction

   // result side backpressure
   always @(posedge clock) begin : rsp_backpressure
      int n;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else begin
         n = pick_gap();
         stall_left <= n;
         rsp_stall <= (n > 0);
      end
   end

   // compare every result transfer with the oldest expected expiry
   always @(posedge clock) begin : expiry_check
      expiry_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_expiries.size() == 0) begin
            $error("unexpected result: expired_valid=%0b expired_id=%0d last=%0b",
                   rsp_expired_valid, rsp_expired_id, rsp_last);
            errors++;
         end else begin
            want = due_expiries.pop_front();
            if (rsp_expired_valid !== want.expired_valid) begin
               $error("expired_valid: expected %0b, got %0b",
                      want.expired_valid, rsp_expired_valid);
               errors++;
            end
            if (rsp_expired_id !== want.id) begin
               $error("expired_id: expected %0d, got %0d", want.id, rsp_expired_id);
               errors++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_last);
               errors++;
            end
         end
      end
   end

   task automatic send_item(logic action, logic [CONN_W-1:0] id);
      int gap;
      req_valid <= 1'b1;
      req_action <= action;
      req_conn_id <= id;
      do
         @(posedge clock);
      while (req_stall);
      predict_expiries(action, id);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (due_expiries.size() != 0)
         @(posedge clock);
   endtask

   task automatic set_wheel_size(logic [CSR_W-1:0] value);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      wheel_cfg = value;
   endtask

   task automatic tick();
      send_item(ACT_TICK, 6'($urandom_range(0, 63)));
   endtask

   task automatic refresh(logic [CONN_W-1:0] id);
      send_item(ACT_REFRESH, id);
   endtask

   // default 60 slot wheel, refresh at position zero lands in the last slot
   task automatic test_reset_wheel();
      refresh(6'd5);
      tick();
      refresh(6'd0);
      refresh(6'd63);
      tick();
   endtask

   // shrink to a two slot wheel at position 2, the next tick wraps; entries in slot 1 expire together
   task automatic test_short_wheel();
      set_wheel_size(7'd2);
      refresh(6'd63);
      tick();
      refresh(6'd17);
      refresh(6'd17);
      tick();
      tick();
   endtask

   // wheel size zero acts as a one slot wheel
   task automatic test_size_zero();
      set_wheel_size(7'd0);
      refresh(6'd10);
      refresh(6'd20);
      refresh(6'd10);
      tick();
      tick();
   endtask

   // entries in slots beyond a reduced wheel wait until it grows again
   task automatic test_stranded();
      set_wheel_size(7'd4);
      refresh(6'd33);
      tick();
      tick();
      set_wheel_size(7'd2);
      repeat (3) tick();
      set_wheel_size(7'd4);
      repeat (3) tick();
   endtask

   // sizes above the slot count clamp to the maximum
   task automatic test_oversize();
      set_wheel_size(7'd127);
      tick();
      refresh(6'd40);
      tick();
      set_wheel_size(7'd65);
      tick();
   endtask

   // every connection expires on one tick
   task automatic test_full_slot();
      set_wheel_size(7'd3);
      for (int i = 0; i < MAX_CONNS; i++)
         refresh(CONN_W'(i) ^ 6'h2a);
      repeat (3) tick();
   endtask

   task automatic test_random_traffic();
      logic [CSR_W-1:0] size;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: size = 7'($urandom_range(1, 8));
            1: size = 7'd0;
            2: size = 7'($urandom_range(65, 127));
            3: size = 7'd64;
            4: size = 7'($urandom_range(9, 63));
            default: size = 7'($urandom_range(2, 5));
         endcase
         set_wheel_size(size);
         calm = (phase % 3 == 2);
         for (int i = 0; i < 3; i++) begin
            if ($urandom_range(0, 99) < 40)
               tick();
            else
               refresh(6'($urandom_range(0, 63)));
            if ($urandom_range(0, 19) == 0)
               drain_results();
         end
         calm = 1'b0;
      end
   endtask

   initial begin
      for (int c = 0; c < MAX_CONNS; c++) begin
         conn_armed[c] = 1'b0;
         conn_slot[c] = '0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_wheel();
      test_short_wheel();
      test_size_zero();
      test_stranded();
      test_oversize();
      test_full_slot();
      test_random_traffic();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

   initial begin
      #30_000_000;
      $display("tb: done, errors");
      $finish;
   end

endmodule
